// ----- design/hir_pkg.sv -----
// Shared types and fixed-point constants for the heat index pipeline.
`default_nettype none
package hir_pkg;

  typedef struct packed {
    logic signed [10:0] temp_c_tenths;
    logic        [9:0]  humidity_tenths;
  } hir_in_t;

  typedef struct packed {
    logic signed [13:0] heat_index_tenths;
    logic        [1:0]  regime;
    logic               saturated;
  } hir_out_t;

  // partial state of the digit-by-digit square root
  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } hir_sqrt_t;

  localparam logic [1:0] REGIME_SIMPLE = 2'd0;
  localparam logic [1:0] REGIME_FULL   = 2'd1;
  localparam logic [1:0] REGIME_LOW_RH = 2'd2;
  localparam logic [1:0] REGIME_HIGH_RH = 2'd3;

  // Rothfusz coefficients, Q.32 magnitudes
  localparam logic signed [35:0] C_T    = 36'sd8800453402;
  localparam logic signed [37:0] C_H    = 38'sd43565276077;
  localparam logic signed [30:0] C_TH   = 31'sd965317136;
  localparam logic signed [25:0] C_T2   = 26'sd29368256;
  localparam logic signed [28:0] C_H2   = 29'sd235437954;
  localparam logic signed [23:0] C_T2H  = 24'sd5277398;
  localparam logic signed [22:0] C_TH2  = 23'sd3662834;
  localparam logic signed [14:0] C_T2H2 = 15'sd8547;

endpackage
`default_nettype wire

// ----- design/hir_sqrt4.sv -----
// Four digit steps of the restoring integer square root.
`default_nettype none
module hir_sqrt4
  import hir_pkg::*;
(
  input  hir_sqrt_t  st_i,
  input  logic [7:0] bits_i,
  output hir_sqrt_t  st_o
);

  always_comb begin
    logic [17:0] rem;
    logic [15:0] root;
    logic [19:0] rem_w;
    logic [19:0] trial;
    rem  = st_i.rem;
    root = st_i.root;
    for (int i = 3; i >= 0; i--) begin
      rem_w = {rem, bits_i[2*i+1], bits_i[2*i]};
      trial = {2'b00, root, 2'b01};
      if (rem_w >= trial) begin
        rem  = 18'(rem_w - trial);
        root = {root[14:0], 1'b1};
      end else begin
        rem  = rem_w[17:0];
        root = {root[14:0], 1'b0};
      end
    end
    st_o.rem  = rem;
    st_o.root = root;
  end

endmodule
`default_nettype wire

// ----- design/heat_index_rothfusz.sv -----
// Top level: nine-stage fixed-point heat index pipeline.
`default_nettype none
// Heat index evaluator. Each transfer carries a temperature in 0.1 degC and
// a relative humidity in 0.1 %; each yields one result of heat index in
// 0.1 degC (saturated to -100.0..800.0 degC), the formula regime used and a
// clip flag. The pipeline takes one item per clock while the output is not
// stalled and has nine register stages; the depth is set by the chain of
// regression products and the four-stage square root of the low-humidity
// correction. Every stage holds its own valid bit, so a stalled output fills
// empty stages before input ready drops.
module heat_index_rothfusz
  import hir_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hir_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hir_out_t out_data_o
);

  localparam int NS = 9;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = ~v_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = ~v_q[k] | adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage 0: degF and %RH in Q.16
  logic signed [25:0] t0_d, t0_q;
  logic signed [23:0] h0_d, h0_q;

  always_comb begin
    logic signed [10:0] tc;
    tc   = in_data_i.temp_c_tenths;
    t0_d = 26'(32'sd2097152 + 32'(tc) * 32'sd11796);
    h0_d = $signed(24'({14'd0, in_data_i.humidity_tenths} * 24'd6554));
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      t0_q <= t0_d;
      h0_q <= h0_d;
    end
  end

  // ---------------- stage 1: squares, linear terms, simple formula, setups
  logic signed [32:0] t2_1q;
  logic signed [30:0] h2_1q;
  logic signed [31:0] th_1q;
  logic signed [23:0] h_1q;
  logic signed [33:0] lin_1q, simple_1q;
  logic signed [19:0] alow_1q;
  logic        [15:0] ratio_1q;
  logic signed [18:0] ha_1q, hb_1q;
  logic        [1:0]  reg_1q;

  logic signed [32:0] t2_1d;
  logic signed [30:0] h2_1d;
  logic signed [31:0] th_1d;
  logic signed [33:0] lin_1d, simple_1d;
  logic signed [19:0] alow_1d;
  logic        [15:0] ratio_1d;
  logic signed [18:0] ha_1d, hb_1d;
  logic        [1:0]  reg_1d;

  always_comb begin
    logic signed [51:0] p_tt;
    logic signed [47:0] p_hh;
    logic signed [49:0] p_th;
    logic signed [61:0] p_ct, p_ch;
    logic signed [26:0] dt68;
    logic signed [44:0] p_s1;
    logic signed [38:0] p_s2;
    logic signed [33:0] s;
    logic signed [26:0] d, dm;
    logic signed [39:0] p_r;
    logic signed [23:0] r;
    logic signed [24:0] hh;
    logic signed [39:0] p_ha;
    logic signed [26:0] tt;
    logic signed [41:0] p_hb;
    p_tt  = 52'(t0_q) * 52'(t0_q);
    p_hh  = 48'(h0_q) * 48'(h0_q);
    p_th  = 50'(t0_q) * 50'(h0_q);
    t2_1d = 33'((p_tt + 52'sd32768) >>> 16);
    h2_1d = 31'((p_hh + 48'sd32768) >>> 16);
    th_1d = 32'((p_th + 50'sd32768) >>> 16);

    p_ct   = 62'(t0_q) * 62'(C_T);
    p_ch   = 62'(h0_q) * 62'(C_H);
    lin_1d = -34'sd2777350 + 34'((p_ct + 62'sd2147483648) >>> 32)
           + 34'((p_ch + 62'sd2147483648) >>> 32);

    dt68 = 27'(t0_q) - 27'sd4456448;
    p_s1 = 45'(dt68) * 45'sd78643;
    p_s2 = 39'(h0_q) * 39'sd6160;
    s    = 34'(t0_q) + 34'sd3997696 + 34'((p_s1 + 45'sd32768) >>> 16)
         + 34'((p_s2 + 39'sd32768) >>> 16);
    simple_1d = s >>> 1;

    // low-humidity correction operands
    alow_1d = 20'((25'sd851968 - 25'(h0_q)) >>> 2);
    d = 27'(t0_q) - 27'sd6225920;
    if (d < 0) d = -d;
    dm  = 27'sd1114112 - d;
    p_r = 40'(dm) * 40'sd3855;
    r   = 24'((p_r + 40'sd32768) >>> 16);
    ratio_1d = (r < 0) ? 16'd0 : r[15:0];

    // high-humidity correction operands
    hh    = 25'(h0_q) - 25'sd5570560;
    p_ha  = 40'(hh) * 40'sd6554;
    ha_1d = 19'((p_ha + 40'sd32768) >>> 16);
    tt    = 27'sd5701632 - 27'(t0_q);
    p_hb  = 42'(tt) * 42'sd13107;
    hb_1d = 19'((p_hb + 42'sd32768) >>> 16);

    if (t0_q < 26'sd5242880) begin
      reg_1d = REGIME_SIMPLE;
    end else if (h0_q < 24'sd851968 && t0_q <= 26'sd7340032) begin
      reg_1d = REGIME_LOW_RH;
    end else if (h0_q > 24'sd5570560 && t0_q <= 26'sd5701632) begin
      reg_1d = REGIME_HIGH_RH;
    end else begin
      reg_1d = REGIME_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      t2_1q     <= t2_1d;
      h2_1q     <= h2_1d;
      th_1q     <= th_1d;
      h_1q      <= h0_q;
      lin_1q    <= lin_1d;
      simple_1q <= simple_1d;
      alow_1q   <= alow_1d;
      ratio_1q  <= ratio_1d;
      ha_1q     <= ha_1d;
      hb_1q     <= hb_1d;
      reg_1q    <= reg_1d;
    end
  end

  // ---------------- stage 2: cubic products, quadratic terms, sqrt digits 1-4
  logic signed [39:0] t2h_2q;
  logic signed [38:0] th2_2q;
  logic signed [45:0] t2h2_2q;
  logic signed [31:0] mth_2q, mt2_2q, mh2_2q;
  logic signed [33:0] lin_2q, simple_2q;
  logic signed [19:0] alow_2q;
  logic signed [19:0] hc_2q;
  logic        [7:0]  rlo_2q;
  hir_sqrt_t          sq_2d, sq_2q;
  logic        [1:0]  reg_2q;

  logic signed [39:0] t2h_2d;
  logic signed [38:0] th2_2d;
  logic signed [45:0] t2h2_2d;
  logic signed [31:0] mth_2d, mt2_2d, mh2_2d;
  logic signed [19:0] hc_2d;

  always_comb begin
    logic signed [56:0] p_t2h;
    logic signed [55:0] p_th2;
    logic signed [63:0] p_t2h2;
    logic signed [62:0] p_mth;
    logic signed [58:0] p_mt2;
    logic signed [59:0] p_mh2;
    logic signed [37:0] p_hc;
    p_t2h   = 57'(t2_1q) * 57'(h_1q);
    p_th2   = 56'(th_1q) * 56'(h_1q);
    p_t2h2  = 64'(t2_1q) * 64'(h2_1q);
    t2h_2d  = 40'((p_t2h + 57'sd32768) >>> 16);
    th2_2d  = 39'((p_th2 + 56'sd32768) >>> 16);
    t2h2_2d = 46'((p_t2h2 + 64'sd32768) >>> 16);
    p_mth   = 63'(th_1q) * 63'(C_TH);
    p_mt2   = 59'(t2_1q) * 59'(C_T2);
    p_mh2   = 60'(h2_1q) * 60'(C_H2);
    mth_2d  = 32'((p_mth + 63'sd2147483648) >>> 32);
    mt2_2d  = 32'((p_mt2 + 59'sd2147483648) >>> 32);
    mh2_2d  = 32'((p_mh2 + 60'sd2147483648) >>> 32);
    p_hc    = 38'(ha_1q) * 38'(hb_1q);
    hc_2d   = 20'((p_hc + 38'sd32768) >>> 16);
  end

  hir_sqrt4 u_sqrt_a (
    .st_i   ('0),
    .bits_i (ratio_1q[15:8]),
    .st_o   (sq_2d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      t2h_2q    <= t2h_2d;
      th2_2q    <= th2_2d;
      t2h2_2q   <= t2h2_2d;
      mth_2q    <= mth_2d;
      mt2_2q    <= mt2_2d;
      mh2_2q    <= mh2_2d;
      lin_2q    <= lin_1q;
      simple_2q <= simple_1q;
      alow_2q   <= alow_1q;
      hc_2q     <= hc_2d;
      rlo_2q    <= ratio_1q[7:0];
      sq_2q     <= sq_2d;
      reg_2q    <= reg_1q;
    end
  end

  // ---------------- stage 3: cubic terms, partial sum, sqrt digits 5-8
  logic signed [31:0] mt2h_3q, mth2_3q, mt2h2_3q;
  logic signed [33:0] acc_3q, simple_3q;
  logic signed [19:0] alow_3q, hc_3q;
  hir_sqrt_t          sq_3d, sq_3q;
  logic        [1:0]  reg_3q;

  logic signed [31:0] mt2h_3d, mth2_3d, mt2h2_3d;
  logic signed [33:0] acc_3d;

  always_comb begin
    logic signed [63:0] p_a;
    logic signed [61:0] p_b;
    logic signed [60:0] p_c;
    p_a      = 64'(t2h_2q) * 64'(C_T2H);
    p_b      = 62'(th2_2q) * 62'(C_TH2);
    p_c      = 61'(t2h2_2q) * 61'(C_T2H2);
    mt2h_3d  = 32'((p_a + 64'sd2147483648) >>> 32);
    mth2_3d  = 32'((p_b + 62'sd2147483648) >>> 32);
    mt2h2_3d = 32'((p_c + 61'sd2147483648) >>> 32);
    acc_3d   = lin_2q - 34'(mth_2q) - 34'(mt2_2q) - 34'(mh2_2q);
  end

  hir_sqrt4 u_sqrt_b (
    .st_i   (sq_2q),
    .bits_i (rlo_2q),
    .st_o   (sq_3d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      mt2h_3q   <= mt2h_3d;
      mth2_3q   <= mth2_3d;
      mt2h2_3q  <= mt2h2_3d;
      acc_3q    <= acc_3d;
      simple_3q <= simple_2q;
      alow_3q   <= alow_2q;
      hc_3q     <= hc_2q;
      sq_3q     <= sq_3d;
      reg_3q    <= reg_2q;
    end
  end

  // ---------------- stage 4: regression sum, sqrt digits 9-12
  logic signed [33:0] full_4q, simple_4q;
  logic signed [19:0] alow_4q, hc_4q;
  hir_sqrt_t          sq_4d, sq_4q;
  logic        [1:0]  reg_4q;
  logic signed [33:0] full_4d;

  assign full_4d = acc_3q + 34'(mt2h_3q) + 34'(mth2_3q) - 34'(mt2h2_3q);

  hir_sqrt4 u_sqrt_c (
    .st_i   (sq_3q),
    .bits_i (8'd0),
    .st_o   (sq_4d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      full_4q   <= full_4d;
      simple_4q <= simple_3q;
      alow_4q   <= alow_3q;
      hc_4q     <= hc_3q;
      sq_4q     <= sq_4d;
      reg_4q    <= reg_3q;
    end
  end

  // ---------------- stage 5: sqrt digits 13-16
  logic signed [33:0] full_5q, simple_5q;
  logic signed [19:0] alow_5q, hc_5q;
  hir_sqrt_t          sq_5d;
  logic        [15:0] root_5q;
  logic        [1:0]  reg_5q;

  hir_sqrt4 u_sqrt_d (
    .st_i   (sq_4q),
    .bits_i (8'd0),
    .st_o   (sq_5d)
  );

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      full_5q   <= full_4q;
      simple_5q <= simple_4q;
      alow_5q   <= alow_4q;
      hc_5q     <= hc_4q;
      root_5q   <= sq_5d.root;
      reg_5q    <= reg_4q;
    end
  end

  // ---------------- stage 6: corrections and regime select (degF, Q.16)
  logic signed [33:0] hi_6d, hi_6q;
  logic        [1:0]  reg_6q;

  always_comb begin
    logic signed [36:0] p_cl;
    logic signed [33:0] cl;
    p_cl = 37'(alow_5q) * 37'($signed({1'b0, root_5q}));
    cl   = 34'((p_cl + 37'sd32768) >>> 16);
    case (reg_5q)
      REGIME_SIMPLE:  hi_6d = simple_5q;
      REGIME_LOW_RH:  hi_6d = full_5q - cl;
      REGIME_HIGH_RH: hi_6d = full_5q + 34'(hc_5q);
      default:        hi_6d = full_5q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      hi_6q  <= hi_6d;
      reg_6q <= reg_5q;
    end
  end

  // ---------------- stage 7: back to degC tenths, Q.16
  logic signed [39:0] p_7d, p_7q;
  logic        [1:0]  reg_7q;

  always_comb begin
    logic signed [34:0] hx;
    logic signed [54:0] p_o;
    hx   = 35'(hi_6q) - 35'sd2097152;
    p_o  = 55'(hx) * 55'sd364089;
    p_7d = 40'((p_o + 55'sd32768) >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      p_7q   <= p_7d;
      reg_7q <= reg_6q;
    end
  end

  // ---------------- stage 8: round, saturate, output register
  hir_out_t out_8d, out_8q;

  always_comb begin
    logic signed [39:0] tn;
    tn = (p_7q + 40'sd32768) >>> 16;
    out_8d.regime = reg_7q;
    if (tn < -40'sd1000) begin
      out_8d.heat_index_tenths = -14'sd1000;
      out_8d.saturated         = 1'b1;
    end else if (tn > 40'sd8000) begin
      out_8d.heat_index_tenths = 14'sd8000;
      out_8d.saturated         = 1'b1;
    end else begin
      out_8d.heat_index_tenths = tn[13:0];
      out_8d.saturated         = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[8]) out_8q <= out_8d;
  end

  assign out_data_o = out_8q;

endmodule
`default_nettype wire
